// ----- src/assert_macros.svh -----
// assertion macros used by the route table engine
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define DVRT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be true at a clock edge out of reset
`define DVRT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- src/dvrt_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the distance-vector route table
// no dependencies
package dvrt_pkg;

	localparam int NODES_DEF      = 64;
	localparam int DIST_WIDTH_DEF = 16;

	localparam int NODE_ID_W = 6;
	localparam int METRIC_W  = 16;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic REG_MY_ID = 1'b0;

	localparam logic KIND_INIT = 1'b0;
	localparam logic KIND_ADV  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADV,
		ST_SWEEP,
		ST_DONE
	} state_t;

endpackage

// ----- src/dvrt_ifs.sv -----
`timescale 1ns / 1ps
// request and response channel interfaces of the route table
// depends on dvrt_pkg
interface dvrt_req_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic [dvrt_pkg::NODE_ID_W-1:0]      neighbor_id;
	logic [dvrt_pkg::METRIC_W-1:0]       link_cost;
	logic [dvrt_pkg::NODE_ID_W-1:0]      dest_id;
	logic [dvrt_pkg::METRIC_W-1:0]       neighbor_distance;

	modport source (output valid, kind, neighbor_id, link_cost, dest_id, neighbor_distance,
		input ready);
	modport sink (input valid, kind, neighbor_id, link_cost, dest_id, neighbor_distance,
		output ready);
endinterface

interface dvrt_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [dvrt_pkg::METRIC_W-1:0]       distance;
	logic [dvrt_pkg::NODE_ID_W-1:0]      next_hop;
	logic                                reachable;
	logic                                changed;

	modport source (output valid, distance, next_hop, reachable, changed, input ready);
	modport sink (input valid, distance, next_hop, reachable, changed, output ready);
endinterface

// ----- src/dvrt_ram.sv -----
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module dvrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/dvrt_apb_regs.sv -----
`timescale 1ns / 1ps
// apb register file holding the router's own node id
// depends on dvrt_pkg
module dvrt_apb_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dvrt_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [dvrt_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [dvrt_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	output logic [dvrt_pkg::NODE_ID_W-1:0]     my_id
);

	logic [dvrt_pkg::NODE_ID_W-1:0] my_id_q;
	logic                           sel_my_id;

	assign sel_my_id = (paddr[2] == dvrt_pkg::REG_MY_ID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_id_q <= '0;
		end else if (psel && penable && pwrite && sel_my_id) begin
			my_id_q <= pwdata[dvrt_pkg::NODE_ID_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_my_id) begin
			prdata = dvrt_pkg::APB_DATA_W'(my_id_q);
		end
	end

	assign pready = 1'b1;
	assign my_id  = my_id_q;

endmodule

// ----- src/dvrt_engine.sv -----
`timescale 1ns / 1ps
// route table engine: read-modify-write of table entries and init sweep
// depends on dvrt_pkg, dvrt_ifs, dvrt_ram, assert_macros.svh
`include "assert_macros.svh"

module dvrt_engine #(
	parameter int NODES      = dvrt_pkg::NODES_DEF,
	parameter int DIST_WIDTH = dvrt_pkg::DIST_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [dvrt_pkg::NODE_ID_W-1:0] my_id,
	dvrt_req_if.sink                       req,
	dvrt_rsp_if.source                     rsp
);

	localparam int IDW     = $clog2(NODES);
	localparam int CW      = $clog2(NODES + 1);
	localparam int HW      = dvrt_pkg::NODE_ID_W;
	localparam int ENTRY_W = DIST_WIDTH + HW + 1;
	localparam int SUM_W   = (DIST_WIDTH > dvrt_pkg::METRIC_W) ? DIST_WIDTH + 1
		: dvrt_pkg::METRIC_W + 1;
	localparam logic [DIST_WIDTH-1:0] INF = {DIST_WIDTH{1'b1}};
	localparam logic [SUM_W-1:0]      INF_EXT = SUM_W'(INF);

	dvrt_pkg::state_t state_q, state_d;

	logic [HW-1:0]                  nb_s1;
	logic [dvrt_pkg::METRIC_W-1:0]  cost_s1;
	logic [dvrt_pkg::METRIC_W-1:0]  ndist_s1;
	logic [HW-1:0]                  dest_s1;
	logic [HW-1:0]                  self_s1;
	logic                           clr_q;
	logic                           diff_q;
	logic [CW-1:0]                  cnt_q;

	logic                           ram_re, ram_we;
	logic [IDW-1:0]                 ram_raddr, ram_waddr;
	logic [ENTRY_W-1:0]             ram_wdata, ram_rdata;

	logic                           out_valid_q;
	logic [dvrt_pkg::METRIC_W-1:0]  out_dist_q;
	logic [HW-1:0]                  out_hop_q;
	logic                           out_reach_q;
	logic                           out_chg_q;
	logic                           out_load;
	logic [dvrt_pkg::METRIC_W-1:0]  res_dist;
	logic [HW-1:0]                  res_hop;
	logic                           res_reach;
	logic                           res_chg;

	logic                           accept, slot_free, dest_ok;
	logic [DIST_WIDTH-1:0]          rd_dist;
	logic [HW-1:0]                  rd_hop;
	logic                           rd_vld;
	logic [SUM_W-1:0]               sum;
	logic                           upd;
	logic [IDW-1:0]                 sw_idx;
	logic                           sw_self;
	logic [ENTRY_W-1:0]             sw_word;
	logic                           sw_diff;
	logic                           sw_last;
	logic                           init_self;

	dvrt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NODES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req.ready = (state_q == dvrt_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign dest_ok   = 32'(dest_s1) < NODES;

	// relaxation of one entry
	assign rd_dist = ram_rdata[DIST_WIDTH-1:0];
	assign rd_hop  = ram_rdata[DIST_WIDTH+HW-1:DIST_WIDTH];
	assign rd_vld  = ram_rdata[ENTRY_W-1];
	assign sum     = SUM_W'(cost_s1) + SUM_W'(ndist_s1);
	assign upd     = dest_ok && (dest_s1 != self_s1) && (nb_s1 != self_s1)
		&& (SUM_W'(cost_s1) < INF_EXT) && (SUM_W'(ndist_s1) < INF_EXT)
		&& (sum < INF_EXT) && (sum < SUM_W'(rd_dist));

	// init sweep, write side trails read side by one entry
	assign sw_idx  = IDW'(cnt_q - CW'(1));
	assign sw_self = (32'(sw_idx) == 32'(self_s1));
	assign sw_word = sw_self ? {1'b1, self_s1, {DIST_WIDTH{1'b0}}} : {1'b0, {HW{1'b0}}, INF};
	assign sw_diff = (ram_rdata != sw_word);
	assign sw_last = (cnt_q == CW'(NODES));
	assign init_self = dest_ok && (dest_s1 == self_s1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dvrt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.kind == dvrt_pkg::KIND_ADV) ? dvrt_pkg::ST_ADV
						: dvrt_pkg::ST_SWEEP;
				end
			end
			dvrt_pkg::ST_ADV: begin
				if (slot_free) begin
					state_d = dvrt_pkg::ST_IDLE;
				end
			end
			dvrt_pkg::ST_SWEEP: begin
				if (sw_last) begin
					state_d = clr_q ? dvrt_pkg::ST_IDLE : dvrt_pkg::ST_DONE;
				end
			end
			dvrt_pkg::ST_DONE: begin
				if (slot_free) begin
					state_d = dvrt_pkg::ST_IDLE;
				end
			end
			default: state_d = dvrt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = IDW'(req.dest_id);
		ram_we    = 1'b0;
		ram_waddr = IDW'(dest_s1);
		ram_wdata = {1'b1, nb_s1, DIST_WIDTH'(sum)};
		out_load  = 1'b0;
		res_dist  = dvrt_pkg::METRIC_W'(INF);
		res_hop   = '0;
		res_reach = 1'b0;
		res_chg   = 1'b0;
		case (state_q)
			dvrt_pkg::ST_IDLE: begin
				ram_re = accept && (req.kind == dvrt_pkg::KIND_ADV);
			end
			dvrt_pkg::ST_ADV: begin
				out_load = slot_free;
				ram_we   = slot_free && upd;
				res_chg  = upd;
				if (upd) begin
					res_dist  = dvrt_pkg::METRIC_W'(DIST_WIDTH'(sum));
					res_hop   = nb_s1;
					res_reach = 1'b1;
				end else if (dest_ok) begin
					res_dist  = dvrt_pkg::METRIC_W'(rd_dist);
					res_hop   = rd_vld ? rd_hop : '0;
					res_reach = rd_vld;
				end
			end
			dvrt_pkg::ST_SWEEP: begin
				ram_re    = !sw_last;
				ram_raddr = IDW'(cnt_q);
				ram_we    = (cnt_q != '0);
				ram_waddr = sw_idx;
				ram_wdata = sw_word;
			end
			dvrt_pkg::ST_DONE: begin
				out_load = slot_free;
				res_chg  = diff_q;
				if (init_self) begin
					res_dist  = '0;
					res_hop   = self_s1;
					res_reach = 1'b1;
				end
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dvrt_pkg::ST_SWEEP;
			clr_q   <= 1'b1;
			cnt_q   <= '0;
			diff_q  <= 1'b0;
			self_s1 <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				self_s1 <= my_id;
				cnt_q   <= '0;
				diff_q  <= 1'b0;
			end else if (state_q == dvrt_pkg::ST_SWEEP) begin
				if (!sw_last) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (cnt_q != '0) begin
					diff_q <= diff_q | sw_diff;
				end
				if (sw_last) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nb_s1    <= req.neighbor_id;
			cost_s1  <= req.link_cost;
			dest_s1  <= req.dest_id;
			ndist_s1 <= req.neighbor_distance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dist_q  <= res_dist;
			out_hop_q   <= res_hop;
			out_reach_q <= res_reach;
			out_chg_q   <= res_chg;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.distance  = out_dist_q;
	assign rsp.next_hop  = out_hop_q;
	assign rsp.reachable = out_reach_q;
	assign rsp.changed   = out_chg_q;

	`DVRT_NEVER(a_rw_same_entry, ram_we && ram_re && (ram_waddr == ram_raddr),
		"table read and write hit the same entry")
	`DVRT_ASSERT(a_accept_leaves_idle, accept |=> (state_q != dvrt_pkg::ST_IDLE),
		"accepted beat did not start work")
	`DVRT_NEVER(a_result_overwrite, out_load && out_valid_q && !rsp.ready,
		"result overwritten before taken")
	`DVRT_ASSERT(a_adv_write_in_range, (ram_we && (state_q == dvrt_pkg::ST_ADV)) |-> dest_ok,
		"update written for out-of-range destination")
	`DVRT_ASSERT(a_sweep_bound, 32'(cnt_q) <= NODES, "sweep counter overran table")

endmodule

// ----- src/distance_vector_route_table_core.sv -----
`timescale 1ns / 1ps
// channel    dir  beat contents
// req        in   kind, neighbor_id, link_cost, dest_id, neighbor_distance
// rsp        out  distance, next_hop, reachable, changed
// apb        in   my_id register at byte address 0
//
// advertisement: a table read, then compare and write back
// init: one entry per cycle through the table ram
// after reset a clearing pass runs, req not taken
// results wait in an output register; an advertisement holds in its
// update cycle until that register is free
// depends on dvrt_pkg, dvrt_ifs, dvrt_apb_regs, dvrt_engine
module distance_vector_route_table_core #(
	parameter int NODES      = dvrt_pkg::NODES_DEF,
	parameter int DIST_WIDTH = dvrt_pkg::DIST_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dvrt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dvrt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dvrt_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	dvrt_req_if.sink                        req,
	dvrt_rsp_if.source                      rsp
);

	logic [dvrt_pkg::NODE_ID_W-1:0] my_id;

	dvrt_apb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.my_id  (my_id)
	);

	dvrt_engine #(
		.NODES     (NODES),
		.DIST_WIDTH(DIST_WIDTH)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.my_id (my_id),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

// ----- test/distance_vector_route_table_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the distance-vector route table core
// mirrors the routing table in a scoreboard class and checks every response beat
// depends on dvrt_pkg, dvrt_ifs and distance_vector_route_table_core
module distance_vector_route_table_core_tb;
	import dvrt_pkg::*;

	localparam int NODES = NODES_DEF;
	localparam bit [METRIC_W-1:0] INF_DIST = '1;
	localparam bit [APB_ADDR_W-1:0] ADDR_MY_ID = {REG_MY_ID, 2'b00};
	localparam bit [APB_ADDR_W-1:0] ADDR_SPARE = 3'b100;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 190;

	typedef enum int {
		PACE_STEADY,
		PACE_TX_GAPS,
		PACE_RX_STALLS,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic                 kind;
		logic [NODE_ID_W-1:0] neighbor;
		logic [METRIC_W-1:0]  cost;
		logic [NODE_ID_W-1:0] dest;
		logic [METRIC_W-1:0]  nbr_dist;
	} route_adv_t;

	typedef struct packed {
		logic [METRIC_W-1:0]  distance;
		logic [NODE_ID_W-1:0] next_hop;
		logic                 reachable;
		logic                 changed;
	} route_entry_t;

	class route_table_mirror;
		bit [NODE_ID_W-1:0] own_id;
		bit [METRIC_W-1:0]  dist_tab[NODES];
		bit [NODE_ID_W-1:0] hop_tab[NODES];
		bit                 hop_ok[NODES];
		route_entry_t       expected_entries[$];
		int                 errors;
		int                 requests;
		int                 inits;
		int                 changes;

		function new();
			own_id = '0;
			void'(rebuild_table());
		endfunction

		function bit rebuild_table();
			bit diff;
			bit [METRIC_W-1:0] d;
			bit [NODE_ID_W-1:0] h;
			bit v;
			diff = 1'b0;
			for (int i = 0; i < NODES; i++) begin
				d = INF_DIST;
				h = '0;
				v = 1'b0;
				if (i == own_id) begin
					d = '0;
					h = own_id;
					v = 1'b1;
				end
				if (dist_tab[i] != d || hop_tab[i] != h || hop_ok[i] != v)
					diff = 1'b1;
				dist_tab[i] = d;
				hop_tab[i] = h;
				hop_ok[i] = v;
			end
			return diff;
		endfunction

		function void write_register(int index, bit [APB_DATA_W-1:0] value);
			if (index == REG_MY_ID)
				own_id = value[NODE_ID_W-1:0];
		endfunction

		function void note_request(route_adv_t a);
			route_entry_t e;
			bit [METRIC_W:0] sum;
			e.changed = 1'b0;
			requests++;
			if (a.kind == KIND_INIT) begin
				inits++;
				e.changed = rebuild_table();
			end else if (a.dest != own_id && a.neighbor != own_id &&
				a.cost != INF_DIST && a.nbr_dist != INF_DIST) begin
				sum = a.cost + a.nbr_dist;
				if (sum < INF_DIST && sum < dist_tab[a.dest]) begin
					e.changed = 1'b1;
					dist_tab[a.dest] = sum[METRIC_W-1:0];
					hop_tab[a.dest] = a.neighbor;
					hop_ok[a.dest] = 1'b1;
				end
			end
			e.distance = dist_tab[a.dest];
			e.next_hop = hop_ok[a.dest] ? hop_tab[a.dest] : '0;
			e.reachable = hop_ok[a.dest];
			expected_entries.push_back(e);
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_entry(route_entry_t got);
			route_entry_t e;
			if (expected_entries.size() == 0) begin
				report("response beat with nothing pending");
				return;
			end
			e = expected_entries.pop_front();
			if (got.changed)
				changes++;
			if (got.distance !== e.distance)
				report($sformatf("distance %0h, expected %0h", got.distance, e.distance));
			if (got.next_hop !== e.next_hop)
				report($sformatf("next_hop %0d, expected %0d", got.next_hop, e.next_hop));
			if (got.reachable !== e.reachable)
				report($sformatf("reachable %0b, expected %0b", got.reachable, e.reachable));
			if (got.changed !== e.changed)
				report($sformatf("changed %0b, expected %0b", got.changed, e.changed));
		endtask

		function int pending();
			return expected_entries.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	dvrt_req_if req_ch();
	dvrt_rsp_if rsp_ch();

	route_table_mirror sb;
	int tx_idle_pct;
	int rx_stall_pct;
	int quiet_cycles;

	distance_vector_route_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_entry({rsp_ch.distance, rsp_ch.next_hop, rsp_ch.reachable,
				rsp_ch.changed});
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic set_pacing(pace_t mode);
		case (mode)
			PACE_STEADY: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			PACE_TX_GAPS: begin
				tx_idle_pct = 56;
				rx_stall_pct = 0;
			end
			PACE_RX_STALLS: begin
				tx_idle_pct = 0;
				rx_stall_pct = 56;
			end
			default: begin
				tx_idle_pct = 13;
				rx_stall_pct = 13;
			end
		endcase
	endtask

	task automatic push_request(route_adv_t a);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.kind = a.kind;
		req_ch.neighbor_id = a.neighbor;
		req_ch.link_cost = a.cost;
		req_ch.dest_id = a.dest;
		req_ch.neighbor_distance = a.nbr_dist;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(a);
	endtask

	// drop valid and let every pending response drain
	task automatic drain(bit with_tail);
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		if (with_tail)
			repeat (NODES + 4) @(posedge clk);
	endtask

	task automatic apb_write(bit [APB_ADDR_W-1:0] addr, bit [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_register(addr >> 2, data);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic apb_read_check();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_MY_ID;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(sb.own_id))
			sb.report($sformatf("my_id reads %0h, expected %0h", prdata, sb.own_id));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic route_adv_t adv(int nb, int cost, int dest, int nd);
		route_adv_t a;
		a.kind = KIND_ADV;
		a.neighbor = NODE_ID_W'(nb);
		a.cost = METRIC_W'(cost);
		a.dest = NODE_ID_W'(dest);
		a.nbr_dist = METRIC_W'(nd);
		return a;
	endfunction

	function automatic route_adv_t init_req(int dest);
		route_adv_t a;
		a = adv($urandom_range(0, NODES - 1), $urandom, dest, $urandom);
		a.kind = KIND_INIT;
		return a;
	endfunction

	function automatic bit [METRIC_W-1:0] pick_metric();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return METRIC_W'($urandom_range(0, 255));
			6, 7: return METRIC_W'($urandom_range(0, 65534));
			8: return INF_DIST;
			default: return METRIC_W'($urandom_range(16'hFF00, 16'hFFFE));
		endcase
	endfunction

	function automatic bit [NODE_ID_W-1:0] pick_node();
		if ($urandom_range(0, 15) == 0)
			return sb.own_id;
		return NODE_ID_W'($urandom_range(0, NODES - 1));
	endfunction

	function automatic route_adv_t random_request();
		if ($urandom_range(0, 39) == 0)
			return init_req($urandom_range(0, NODES - 1));
		return adv(pick_node(), pick_metric(), pick_node(), pick_metric());
	endfunction

	initial begin
		bit [NODE_ID_W-1:0] phase_ids[8];
		bit [APB_DATA_W-1:0] v;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_INIT;
		req_ch.neighbor_id = '0;
		req_ch.link_cost = '0;
		req_ch.dest_id = '0;
		req_ch.neighbor_distance = '0;
		rsp_ch.ready = 1'b0;
		quiet_cycles = 0;
		set_pacing(PACE_STEADY);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// clearing pass after reset
		repeat (NODES + 8) @(posedge clk);

		apb_read_check();
		apb_write(ADDR_MY_ID, '0);
		push_request(init_req(0));
		push_request(adv(1, 3, 2, 4));
		push_request(adv(3, 7, 2, 0));
		push_request(adv(3, 6, 2, 0));
		// destination is self, then neighbor is self
		push_request(adv(5, 1, 0, 1));
		push_request(adv(0, 1, 4, 1));
		// infinite operands and sums at, beyond and just below infinity
		push_request(adv(5, INF_DIST, 6, 0));
		push_request(adv(5, 0, 6, INF_DIST));
		push_request(adv(5, 16'h8000, 6, 16'h7FFF));
		push_request(adv(5, 16'hFFFE, 6, 16'hFFFE));
		push_request(adv(5, 0, 6, 16'hFFFE));
		push_request(adv(63, 0, 63, 0));
		push_request(adv(63, 1, 63, 0));
		push_request(adv(42, 0, 6, 0));
		push_request(init_req(63));
		push_request(init_req(6));
		drain(1'b1);

		// new id applies to advertisements at once; the table's own entry moves only at the next init
		apb_write(ADDR_MY_ID, 32'hFFFF_FFFF);
		apb_read_check();
		set_pacing(PACE_BOTH);
		push_request(adv(1, 1, 63, 1));
		push_request(adv(1, 0, 0, 0));
		push_request(init_req(0));
		push_request(adv(1, 1, 63, 1));
		push_request(adv(63, 2, 5, 2));
		push_request(adv(62, 1, 5, 1));
		drain(1'b1);
		apb_write(ADDR_SPARE, $urandom);
		apb_read_check();

		phase_ids = '{6'd0, 6'd63, 6'($urandom), 6'($urandom), 6'd1, 6'd62,
			6'($urandom), 6'd32};
		for (int p = 0; p < 8; p++) begin
			drain(1'b1);
			v = $urandom;
			v[NODE_ID_W-1:0] = phase_ids[p];
			apb_write(ADDR_MY_ID, v);
			if (p % 2 == 1)
				apb_write(ADDR_SPARE, $urandom);
			apb_read_check();
			set_pacing(pace_t'(p % 4));
			push_request(init_req(pick_node()));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 1 && k == PHASE_ITEMS / 2)
					drain(1'b0);
				push_request(random_request());
			end
		end
		drain(1'b1);

		$display("covered %0d requests, %0d of them table inits, %0d beats reporting a change",
			sb.requests, sb.inits, sb.changes);
		$display("router ids swept over both extremes, all four pacing modes exercised");
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
